// ----- rtl/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the closest factor search block: sequencer
// states, stream field widths and the first trial divisor.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // field widths of one transfer
  localparam int TARGET_W    = 32;
  localparam int NUMBER_W    = 32;
  localparam int FACTOR_W    = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;

  // bit positions inside the input tdata
  localparam int TARGET_LSB   = 0;
  localparam int NUMBER_LSB   = 32;
  localparam int ROUND_UP_BIT = 64;

  // trial division starts here
  localparam int FIRST_DIVISOR = 2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DIST,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/cfs_div.sv -----
// ----------------------------------------------------------------------------
// cfs_div
// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses once quotient and remainder are valid.
// ----------------------------------------------------------------------------
module cfs_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_sub;

  // one shift and subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[WIDTH-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
      if (!rem_sub[WIDTH]) begin
        rem_d = rem_sub[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/closest_factor_search_core.sv -----
// ----------------------------------------------------------------------------
// closest_factor_search_core
// Finds the divisor of a number, between 2 and its integer square root, that
// lies closest to a target, by trial division on one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transfer carries target, number and round_up. m_axis: one
//   transfer per input, found in tuser and the factor in tdata (zero if none).
//   One item at a time; s_axis_tready_o is high only while the sequencer idles.
//   Each trial divisor i = 2, 3, ... costs a start state and one divider
//   pass, and a hit also passes the distance and compare states. The search
//   stops at the first i with i > number / i. Invalid items (number not
//   positive, target negative) skip the search and go straight to the final
//   state. The sequencer returns to idle as the result is loaded, so the next
//   item is accepted even while that result waits; if the receiver still
//   holds off when that search ends, the sequencer waits in its final state
//   until the register is free.
//   Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module closest_factor_search_core #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // target [31:0], number [63:32], round_up [64], zero pad [71:65]
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [cfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // factor [15:0]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [cfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // found [0]
  output logic                            m_axis_tuser_o
);

  localparam int NW = NUMBER_WIDTH;
  localparam int DistW = ((NW > cfs_pkg::TARGET_W) ? NW : cfs_pkg::TARGET_W) + 1;

  cfs_pkg::state_e state_q, state_d;

  logic [cfs_pkg::TARGET_W-1:0] target_q;
  logic                         round_up_q;
  logic [NW-1:0]                num_q;
  logic [NW-1:0]                i_q;
  logic [NW-1:0]                best_q;
  logic [DistW-1:0]             best_dist_q;
  logic [DistW-1:0]             dist_q;
  logic                         have_q;
  logic                         m_valid_q;
  logic                         m_found_q;
  logic [cfs_pkg::FACTOR_W-1:0] m_factor_q;

  logic [cfs_pkg::TARGET_W-1:0] in_target;
  logic [cfs_pkg::NUMBER_W-1:0] in_number;
  logic [NW-1:0]                in_num;
  logic                         in_neg;
  logic                         in_bad;
  logic                         in_xfer;
  logic                         out_xfer;

  logic                         div_start;
  logic                         div_done;
  logic [NW-1:0]                div_quo;
  logic [NW-1:0]                div_rem;
  logic                         past_root;
  logic [DistW-1:0]             diff;
  logic                         take;
  logic                         load_out;

  // unpack the input transfer
  assign in_target = s_axis_tdata_i[cfs_pkg::TARGET_LSB +: cfs_pkg::TARGET_W];
  assign in_number = s_axis_tdata_i[cfs_pkg::NUMBER_LSB +: cfs_pkg::NUMBER_W];
  assign in_num    = NW'(in_number);
  assign in_neg    = (NW <= cfs_pkg::NUMBER_W) ? in_num[NW-1] : 1'b0;
  assign in_bad    = in_neg || (in_num == '0) || in_target[cfs_pkg::TARGET_W-1];

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_valid_q && m_axis_tready_i;

  // shared trial divider
  cfs_div #(
    .WIDTH (NW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (num_q),
    .divisor_i   (i_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // search ends once the divisor passes the quotient
  assign past_root = i_q > div_quo;

  // signed distance of the divisor to the target
  assign diff = DistW'(target_q) - DistW'(i_q);

  // keep the first hit, a nearer one, or an equal one when rounding up
  assign take = !have_q || (dist_q < best_dist_q) || ((dist_q == best_dist_q) && round_up_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cfs_pkg::ST_IDLE: begin
        if (in_xfer) state_d = in_bad ? cfs_pkg::ST_DONE : cfs_pkg::ST_START;
      end
      cfs_pkg::ST_START: state_d = cfs_pkg::ST_DIV;
      cfs_pkg::ST_DIV: begin
        if (div_done) begin
          if (past_root) state_d = cfs_pkg::ST_DONE;
          else if (div_rem == '0) state_d = cfs_pkg::ST_DIST;
          else state_d = cfs_pkg::ST_START;
        end
      end
      cfs_pkg::ST_DIST: state_d = cfs_pkg::ST_CMP;
      cfs_pkg::ST_CMP: state_d = cfs_pkg::ST_START;
      cfs_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) state_d = cfs_pkg::ST_IDLE;
      end
      default: state_d = cfs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      cfs_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      cfs_pkg::ST_START: div_start = 1'b1;
      cfs_pkg::ST_DONE:  load_out = !m_valid_q || m_axis_tready_i;
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cfs_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) m_valid_q <= 1'b1;
      else if (out_xfer) m_valid_q <= 1'b0;
      if (in_xfer) have_q <= 1'b0;
      else if (state_q == cfs_pkg::ST_CMP && take) have_q <= 1'b1;
    end
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      target_q   <= in_target;
      num_q      <= in_num;
      round_up_q <= s_axis_tdata_i[cfs_pkg::ROUND_UP_BIT];
      i_q        <= NW'(cfs_pkg::FIRST_DIVISOR);
    end
    if (state_q == cfs_pkg::ST_DIV && div_done && !past_root && div_rem != '0) begin
      i_q <= i_q + 1'b1;
    end
    if (state_q == cfs_pkg::ST_DIST) begin
      dist_q <= diff[DistW-1] ? (~diff + 1'b1) : diff;
    end
    if (state_q == cfs_pkg::ST_CMP) begin
      i_q <= i_q + 1'b1;
      if (take) begin
        best_q      <= i_q;
        best_dist_q <= dist_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_found_q  <= have_q;
      m_factor_q <= have_q ? cfs_pkg::FACTOR_W'(best_q) : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_factor_q;
  assign m_axis_tuser_o  = m_found_q;

`ifndef SYNTHESIS
  // a reported factor is at least the first trial divisor
  a_found_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_found_q |-> m_factor_q >= cfs_pkg::FACTOR_W'(cfs_pkg::FIRST_DIVISOR))
    else $error("found result carries factor below first divisor");

  // no result means a zero factor
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_found_q |-> m_factor_q == '0)
    else $error("not-found result carries nonzero factor");

  // the trial divisor never drops below the first divisor during a search
  a_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cfs_pkg::ST_START |-> i_q >= NW'(cfs_pkg::FIRST_DIVISOR))
    else $error("trial divisor below first divisor");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready_i |=> m_valid_q && $stable(m_factor_q))
    else $error("pending result lost");
`endif

endmodule
